// ----- rtl/core/ttab_pkg.sv -----
// shared types, constants and helpers for the task table engine
`default_nettype none

package ttab_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  // field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned SLOT_W = 3;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = idx_t'(TABLE_DEPTH - 1);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_RESUME  = 3'd3,
    CMD_SLEEP   = 3'd4,
    CMD_WAKE    = 3'd5
  } cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ACT,
    ST_SH_RD,
    ST_SH_WR,
    ST_CLEAR
  } state_e;

  // one table entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              susp;
    logic [TIME_W-1:0] timer;
  } entry_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic   we;
    logic   clr;
    idx_t   waddr;
    idx_t   raddr;
    entry_t wdata;
  } mem_req_t;

  // sequencer to search unit
  typedef struct packed {
    logic            start;
    logic            chk;
    idx_t            idx;
    logic [ID_W-1:0] key;
  } scan_ctl_t;

  // search unit findings
  typedef struct packed {
    logic   match_hit;
    idx_t   match_idx;
    entry_t match_entry;
    logic   free_hit;
    idx_t   free_idx;
    idx_t   end_idx;
  } scan_res_t;

  // slot index reported modulo the slot field range
  function automatic logic [SLOT_W-1:0] to_slot(input idx_t idx);
    logic [SLOT_W+IDX_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ttab_mem.sv -----
// entry memory with per-slot valid bits, one write and one registered read port
`default_nettype none

module ttab_mem (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  ttab_pkg::mem_req_t req_i,
  output ttab_pkg::entry_t   rdata_o
);

  ttab_pkg::entry_t                    mem_q [ttab_pkg::TABLE_DEPTH];
  logic [ttab_pkg::TABLE_DEPTH-1:0]    valid_q;
  ttab_pkg::entry_t                    rdata_q;
  logic                                rvalid_q;

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  // valid bits, cleared at reset so the table reads empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end else if (req_i.clr) begin
        valid_q[req_i.waddr] <= 1'b0;
      end
      rvalid_q <= valid_q[req_i.raddr];
    end
  end

  // an unwritten or cleared slot reads as an empty entry
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- rtl/core/ttab_scan.sv -----
// search unit: tracks match, first free slot and shift end over a table sweep
`default_nettype none

module ttab_scan (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ttab_pkg::scan_ctl_t ctl_i,
  input  ttab_pkg::entry_t    rdata_i,
  output ttab_pkg::scan_res_t res_o
);

  logic             match_hit_q, match_hit_d;
  logic             free_hit_q, free_hit_d;
  logic             end_hit_q, end_hit_d;
  ttab_pkg::idx_t   match_idx_q, match_idx_d;
  ttab_pkg::idx_t   free_idx_q, free_idx_d;
  ttab_pkg::idx_t   end_idx_q, end_idx_d;
  ttab_pkg::entry_t match_entry_q, match_entry_d;
  logic             is_match;
  logic             is_empty;

  assign is_match = (ctl_i.key != '0) && (rdata_i.id == ctl_i.key);
  assign is_empty = (rdata_i.id == '0);

  // update findings with the slot read last cycle
  always_comb begin
    match_hit_d   = match_hit_q;
    free_hit_d    = free_hit_q;
    end_hit_d     = end_hit_q;
    match_idx_d   = match_idx_q;
    free_idx_d    = free_idx_q;
    end_idx_d     = end_idx_q;
    match_entry_d = match_entry_q;
    if (ctl_i.start) begin
      match_hit_d = 1'b0;
      free_hit_d  = 1'b0;
      end_hit_d   = 1'b0;
      end_idx_d   = ttab_pkg::LAST_IDX;
    end else if (ctl_i.chk) begin
      if (!match_hit_q && is_match) begin
        match_hit_d   = 1'b1;
        match_idx_d   = ctl_i.idx;
        match_entry_d = rdata_i;
      end
      if (!free_hit_q && is_empty) begin
        free_hit_d = 1'b1;
        free_idx_d = ctl_i.idx;
      end
      // first empty slot after the match ends a delete shift
      if (match_hit_q && !end_hit_q && is_empty) begin
        end_hit_d = 1'b1;
        end_idx_d = ctl_i.idx;
      end
    end
  end

  // flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      end_hit_q   <= 1'b0;
      end_idx_q   <= ttab_pkg::LAST_IDX;
    end else begin
      match_hit_q <= match_hit_d;
      free_hit_q  <= free_hit_d;
      end_hit_q   <= end_hit_d;
      end_idx_q   <= end_idx_d;
    end
  end

  // captured indexes and matched entry
  always_ff @(posedge clk_i) begin
    match_idx_q   <= match_idx_d;
    free_idx_q    <= free_idx_d;
    match_entry_q <= match_entry_d;
  end

  assign res_o.match_hit   = match_hit_q;
  assign res_o.match_idx   = match_idx_q;
  assign res_o.match_entry = match_entry_q;
  assign res_o.free_hit    = free_hit_q;
  assign res_o.free_idx    = free_idx_q;
  assign res_o.end_idx     = end_idx_q;

endmodule

`default_nettype wire

// ----- rtl/core/ttab_ctrl.sv -----
// command sequencer: sweep, read-modify-write, delete shift and result
`default_nettype none

module ttab_ctrl (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [ttab_pkg::CMD_W-1:0]          command_i,
  input  wire  [ttab_pkg::ID_W-1:0]           task_id_i,
  input  wire  [ttab_pkg::PRIO_W-1:0]         priority_req_i,
  input  wire  [ttab_pkg::TIME_W-1:0]         sleep_time_i,
  output logic                                done_o,
  output logic                                ok_o,
  output logic [ttab_pkg::SLOT_W-1:0]         slot_o,
  output ttab_pkg::mem_req_t                  mem_req_o,
  input  ttab_pkg::entry_t                    rdata_i,
  output ttab_pkg::scan_ctl_t                 scan_ctl_o,
  input  ttab_pkg::scan_res_t                 scan_res_i
);

  ttab_pkg::state_e              state_q, state_d;
  ttab_pkg::idx_t                cnt_q, cnt_d;
  logic                          chk_q, chk_d;
  ttab_pkg::idx_t                chk_idx_q, chk_idx_d;
  logic                          done_q, done_d;
  logic                          ok_q, ok_d;
  logic [ttab_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [ttab_pkg::CMD_W-1:0]    cmd_q;
  logic [ttab_pkg::ID_W-1:0]     id_q;
  logic [ttab_pkg::PRIO_W-1:0]   prio_q;
  logic [ttab_pkg::TIME_W-1:0]   time_q;
  logic                          accept;
  logic                          act_ok;
  logic                          act_wr;
  ttab_pkg::idx_t                act_idx;
  ttab_pkg::entry_t              act_entry;
  ttab_pkg::idx_t                cnt_inc;

  assign busy    = (state_q != ttab_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign cnt_inc = ttab_pkg::idx_t'(cnt_q + 1'b1);

  // command decode on the finished sweep
  always_comb begin
    act_ok    = 1'b0;
    act_wr    = 1'b0;
    act_idx   = scan_res_i.match_idx;
    act_entry = scan_res_i.match_entry;
    unique case (cmd_q)
      ttab_pkg::CMD_CREATE: begin
        act_ok          = (id_q != '0) && !scan_res_i.match_hit && scan_res_i.free_hit;
        act_wr          = act_ok;
        act_idx         = scan_res_i.free_idx;
        act_entry.id    = id_q;
        act_entry.prio  = prio_q;
        act_entry.susp  = 1'b0;
        act_entry.timer = '0;
      end
      ttab_pkg::CMD_DELETE: begin
        act_ok = scan_res_i.match_hit;
      end
      ttab_pkg::CMD_SUSPEND: begin
        act_ok         = scan_res_i.match_hit;
        act_wr         = act_ok;
        act_entry.susp = 1'b1;
      end
      ttab_pkg::CMD_RESUME: begin
        act_ok         = scan_res_i.match_hit;
        act_wr         = act_ok;
        act_entry.susp = 1'b0;
      end
      ttab_pkg::CMD_SLEEP: begin
        act_ok = scan_res_i.match_hit;
        act_wr = act_ok;
        if (scan_res_i.match_entry.timer < time_q) begin
          act_entry.timer = time_q;
        end
      end
      ttab_pkg::CMD_WAKE: begin
        act_ok          = scan_res_i.match_hit;
        act_wr          = act_ok;
        act_entry.timer = '0;
      end
      default: begin
        act_ok = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttab_pkg::ST_IDLE: begin
        if (start) state_d = ttab_pkg::ST_SCAN;
      end
      ttab_pkg::ST_SCAN: begin
        if (cnt_q == ttab_pkg::LAST_IDX) state_d = ttab_pkg::ST_DRAIN;
      end
      ttab_pkg::ST_DRAIN: begin
        state_d = ttab_pkg::ST_ACT;
      end
      ttab_pkg::ST_ACT: begin
        if (cmd_q == ttab_pkg::CMD_DELETE && scan_res_i.match_hit) begin
          if (scan_res_i.end_idx == scan_res_i.match_idx) begin
            state_d = ttab_pkg::ST_CLEAR;
          end else begin
            state_d = ttab_pkg::ST_SH_RD;
          end
        end else begin
          state_d = ttab_pkg::ST_IDLE;
        end
      end
      ttab_pkg::ST_SH_RD: begin
        state_d = ttab_pkg::ST_SH_WR;
      end
      ttab_pkg::ST_SH_WR: begin
        if (cnt_inc == scan_res_i.end_idx) begin
          state_d = ttab_pkg::ST_CLEAR;
        end else begin
          state_d = ttab_pkg::ST_SH_RD;
        end
      end
      ttab_pkg::ST_CLEAR: begin
        state_d = ttab_pkg::ST_IDLE;
      end
      default: begin
        state_d = ttab_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs: memory port, sweep pointer, result
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.clr   = 1'b0;
    mem_req_o.waddr = cnt_q;
    mem_req_o.raddr = cnt_q;
    mem_req_o.wdata = rdata_i;
    cnt_d           = cnt_q;
    chk_d           = 1'b0;
    chk_idx_d       = cnt_q;
    done_d          = 1'b0;
    ok_d            = 1'b0;
    slot_d          = '0;
    unique case (state_q)
      ttab_pkg::ST_IDLE: begin
        if (start) cnt_d = '0;
      end
      ttab_pkg::ST_SCAN: begin
        chk_d = 1'b1;
        cnt_d = cnt_inc;
      end
      ttab_pkg::ST_DRAIN: begin
        cnt_d = cnt_q;
      end
      ttab_pkg::ST_ACT: begin
        mem_req_o.we    = act_wr;
        mem_req_o.waddr = act_idx;
        mem_req_o.wdata = act_entry;
        cnt_d           = scan_res_i.match_idx;
        // delete reports once the shift is done
        if (!(cmd_q == ttab_pkg::CMD_DELETE && act_ok)) begin
          done_d = 1'b1;
          ok_d   = act_ok;
          slot_d = act_ok ? ttab_pkg::to_slot(act_idx) : '0;
        end
      end
      ttab_pkg::ST_SH_RD: begin
        mem_req_o.raddr = cnt_inc;
      end
      ttab_pkg::ST_SH_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q;
        mem_req_o.wdata = rdata_i;
        cnt_d           = cnt_inc;
      end
      ttab_pkg::ST_CLEAR: begin
        mem_req_o.clr   = 1'b1;
        mem_req_o.waddr = scan_res_i.end_idx;
        done_d          = 1'b1;
        ok_d            = 1'b1;
        slot_d          = ttab_pkg::to_slot(scan_res_i.match_idx);
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttab_pkg::ST_IDLE;
      cnt_q     <= '0;
      chk_q     <= 1'b0;
      chk_idx_q <= '0;
      done_q    <= 1'b0;
      ok_q      <= 1'b0;
      slot_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_q     <= chk_d;
      chk_idx_q <= chk_idx_d;
      done_q    <= done_d;
      ok_q      <= ok_d;
      slot_q    <= slot_d;
    end
  end

  // command item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      id_q   <= task_id_i;
      prio_q <= priority_req_i;
      time_q <= sleep_time_i;
    end
  end

  assign scan_ctl_o.start = accept;
  assign scan_ctl_o.chk   = chk_q;
  assign scan_ctl_o.idx   = chk_idx_q;
  assign scan_ctl_o.key   = id_q;

  assign done_o = done_q;
  assign ok_o   = ok_q;
  assign slot_o = slot_q;

  // a result is only issued as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ttab_pkg::ST_IDLE))
    else $error("result strobe while sequencer busy");

  // a failed command reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !ok_q) |-> (slot_q == '0))
    else $error("nonzero slot on failed command");

  // an accepted item starts a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ttab_pkg::ST_SCAN && cnt_q == '0))
    else $error("accepted item did not start sweep");

  // the shift pointer stays below the end of the shift
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ttab_pkg::ST_SH_RD) |-> (cnt_q < scan_res_i.end_idx))
    else $error("delete shift ran past its end");

endmodule

`default_nettype wire

// ----- rtl/core/task_table_engine.sv -----
// top level of the task table engine
//
// Command channel: an item (command_i, task_id_i, priority_req_i,
// sleep_time_i) is taken at a rising edge with start high and busy low.
// Result channel: done_o marks one cycle in which ok_o and slot_o hold the
// result of the item; the receiver cannot stall it, so it must sample then.
// Each command sweeps the whole table through the entry memory, one slot
// read per cycle, then a successful create, suspend, resume, sleep or wake
// writes the modified entry back to the chosen slot once. Busy drops in
// time for the next item to be taken in the cycle of the strobe. A delete
// that hits instead moves the later entries up one slot (one memory read,
// one write each) and then clears the vacated slot. The memory sets the
// pace: the sweep reads one slot per cycle and the shift reads and then
// writes each moved entry; where a read and a write meet on one slot, the
// read data is unused, so no forwarding is needed.
// Reset clears every slot's valid bit at once; the table is empty and an
// item can be taken in the first cycle after reset.
`default_nettype none

module task_table_engine (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [ttab_pkg::CMD_W-1:0]   command_i,
  input  wire  [ttab_pkg::ID_W-1:0]    task_id_i,
  input  wire  [ttab_pkg::PRIO_W-1:0]  priority_req_i,
  input  wire  [ttab_pkg::TIME_W-1:0]  sleep_time_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [ttab_pkg::SLOT_W-1:0]  slot_o
);

  ttab_pkg::mem_req_t  mem_req;
  ttab_pkg::entry_t    rdata;
  ttab_pkg::scan_ctl_t scan_ctl;
  ttab_pkg::scan_res_t scan_res;

  // sequencer
  ttab_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .sleep_time_i   (sleep_time_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .slot_o         (slot_o),
    .mem_req_o      (mem_req),
    .rdata_i        (rdata),
    .scan_ctl_o     (scan_ctl),
    .scan_res_i     (scan_res)
  );

  // entry memory
  ttab_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // search unit
  ttab_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .rdata_i (rdata),
    .res_o   (scan_res)
  );

endmodule

`default_nettype wire

// ----- test/task_table_engine_tb.sv -----
// testbench for the task table engine: queued command driver, result monitor, table predictor
`timescale 1ns / 1ps

module task_table_engine_tb;

  // undefined command codes, rejected by the block without changing the table
  localparam logic [ttab_pkg::CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [ttab_pkg::CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  localparam int unsigned N_RANDOM     = 1100;
  localparam int unsigned POOL_SIZE    = 12;
  localparam int unsigned SETTLE_CYCLES = 4 * ttab_pkg::TABLE_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // one command item as queued for the driver
  typedef struct {
    logic [ttab_pkg::CMD_W-1:0]  cmd;
    logic [ttab_pkg::ID_W-1:0]   id;
    logic [ttab_pkg::PRIO_W-1:0] prio;
    logic [ttab_pkg::TIME_W-1:0] ticks;
    bit                          hold;
  } command_t;

  // one expected result
  typedef struct {
    logic                        ok;
    logic [ttab_pkg::SLOT_W-1:0] slot;
  } reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                        start_r = 1'b0;
  logic [ttab_pkg::CMD_W-1:0]  command_r = '0;
  logic [ttab_pkg::ID_W-1:0]   task_id_r = '0;
  logic [ttab_pkg::PRIO_W-1:0] priority_r = '0;
  logic [ttab_pkg::TIME_W-1:0] sleep_time_r = '0;

  logic                        busy;
  logic                        done_o;
  logic                        ok_o;
  logic [ttab_pkg::SLOT_W-1:0] slot_o;

  // predicted task table
  logic [ttab_pkg::ID_W-1:0]   tbl_id    [ttab_pkg::TABLE_DEPTH];
  logic [ttab_pkg::PRIO_W-1:0] tbl_prio  [ttab_pkg::TABLE_DEPTH];
  logic                        tbl_susp  [ttab_pkg::TABLE_DEPTH];
  logic [ttab_pkg::TIME_W-1:0] tbl_timer [ttab_pkg::TABLE_DEPTH];

  command_t pending_q[$];
  reply_t   reply_q[$];

  logic [ttab_pkg::ID_W-1:0] id_pool [POOL_SIZE];

  int n_pred = 0;
  int n_seen = 0;
  int n_ok = 0;
  int n_errors = 0;
  int n_by_cmd [8];
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  task_table_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start_r),
    .busy           (busy),
    .command_i      (command_r),
    .task_id_i      (task_id_r),
    .priority_req_i (priority_r),
    .sleep_time_i   (sleep_time_r),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .slot_o         (slot_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // table update and expected result for one accepted item
  task automatic predict_reply(input command_t c, output reply_t r);
    int hit;
    int used;
    int i;
    hit = -1;
    used = -1;
    if (c.id != '0) begin
      for (i = 0; i < ttab_pkg::TABLE_DEPTH; i++) begin
        if (hit < 0 && tbl_id[i] == c.id) hit = i;
      end
    end
    if (c.cmd == ttab_pkg::CMD_CREATE) begin
      if (c.id != '0 && hit < 0) begin
        for (i = 0; i < ttab_pkg::TABLE_DEPTH; i++) begin
          if (used < 0 && tbl_id[i] == '0) begin
            used = i;
            tbl_id[i]    = c.id;
            tbl_prio[i]  = c.prio;
            tbl_susp[i]  = 1'b0;
            tbl_timer[i] = '0;
          end
        end
      end
    end else if (c.cmd <= ttab_pkg::CMD_WAKE && hit >= 0) begin
      used = hit;
      case (c.cmd)
        ttab_pkg::CMD_DELETE: begin
          // pull later entries up until an empty slot or the end is copied
          i = hit;
          while (i + 1 < ttab_pkg::TABLE_DEPTH && tbl_id[i] != '0) begin
            tbl_id[i]    = tbl_id[i+1];
            tbl_prio[i]  = tbl_prio[i+1];
            tbl_susp[i]  = tbl_susp[i+1];
            tbl_timer[i] = tbl_timer[i+1];
            i++;
          end
          tbl_id[i]    = '0;
          tbl_prio[i]  = '0;
          tbl_susp[i]  = 1'b0;
          tbl_timer[i] = '0;
        end
        ttab_pkg::CMD_SUSPEND: tbl_susp[hit] = 1'b1;
        ttab_pkg::CMD_RESUME:  tbl_susp[hit] = 1'b0;
        ttab_pkg::CMD_SLEEP: begin
          if (tbl_timer[hit] < c.ticks) tbl_timer[hit] = c.ticks;
        end
        default: tbl_timer[hit] = '0;
      endcase
    end
    r.ok   = (used >= 0);
    r.slot = (used >= 0) ? used[ttab_pkg::SLOT_W-1:0] : '0;
  endtask

  task automatic queue_command(input logic [ttab_pkg::CMD_W-1:0] cmd,
                               input logic [ttab_pkg::ID_W-1:0] id,
                               input logic [ttab_pkg::PRIO_W-1:0] prio,
                               input logic [ttab_pkg::TIME_W-1:0] ticks, input bit hold);
    command_t c;
    c.cmd   = cmd;
    c.id    = id;
    c.prio  = prio;
    c.ticks = ticks;
    c.hold  = hold;
    pending_q.push_back(c);
  endtask

  // driver: present queued items in bursts, hold each until taken
  always @(posedge clk_i) begin : drive
    logic   taken;
    logic   present;
    reply_t rep;
    taken = 1'b0;
    present = 1'b0;
    if (rst_ni) begin
      if (start_r && !busy) begin
        taken = 1'b1;
        predict_reply(pending_q[0], rep);
        reply_q.push_back(rep);
        n_pred++;
        n_by_cmd[pending_q[0].cmd]++;
        pending_q.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = $urandom_range(1, 14);
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 6);
        end
      end
      if (start_r && !taken) begin
        present = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0 && !(pending_q[0].hold && n_seen != n_pred)) begin
        present = 1'b1;
      end
    end
    start_r <= present;
    if (present) begin
      command_r    <= pending_q[0].cmd;
      task_id_r    <= pending_q[0].id;
      priority_r   <= pending_q[0].prio;
      sleep_time_r <= pending_q[0].ticks;
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin : check
    reply_t want;
    if (rst_ni && done_o === 1'b1) begin
      n_seen <= n_seen + 1;
      if (reply_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual ok=%0b slot=%0d",
                 $time, ok_o, slot_o);
      end else begin
        want = reply_q.pop_front();
        if (ok_o === 1'b1) n_ok++;
        if (ok_o !== want.ok) begin
          n_errors++;
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok_o);
        end
        if (slot_o !== want.slot) begin
          n_errors++;
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, slot_o);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int                          i;
    int                          r;
    int                          s;
    int                          p;
    logic [ttab_pkg::CMD_W-1:0]  cmd;
    logic [ttab_pkg::ID_W-1:0]   id;
    logic [ttab_pkg::TIME_W-1:0] ticks;

    for (i = 0; i < ttab_pkg::TABLE_DEPTH; i++) begin
      tbl_id[i] = '0;
      tbl_prio[i] = '0;
      tbl_susp[i] = 1'b0;
      tbl_timer[i] = '0;
    end
    for (i = 0; i < 8; i++) n_by_cmd[i] = 0;

    // directed: id zero, unknown id, duplicate, field extremes
    queue_command(ttab_pkg::CMD_CREATE, 16'h0000, 8'hFF, 16'hFFFF, 1'b0);
    queue_command(ttab_pkg::CMD_DELETE, 16'h1234, 8'h00, 16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_CREATE, 16'hFFFF, 8'hFF, 16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_CREATE, 16'hFFFF, 8'h11, 16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_CREATE, 16'h0001, 8'h00, 16'hFFFF, 1'b0);
    queue_command(ttab_pkg::CMD_SUSPEND, 16'hFFFF, 8'h00, 16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_RESUME, 16'hFFFF, 8'h00, 16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_SLEEP, 16'hFFFF, 8'h00, 16'hFFFF, 1'b0);
    queue_command(ttab_pkg::CMD_SLEEP, 16'hFFFF, 8'h00, 16'h0001, 1'b0);
    queue_command(ttab_pkg::CMD_WAKE, 16'hFFFF, 8'h00, 16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_SUSPEND, 16'h0000, 8'h00, 16'h0000, 1'b0);
    // undefined codes naming a stored id
    queue_command(CMD_UNDEF_LO, 16'hFFFF, 8'h00, 16'h0000, 1'b0);
    queue_command(CMD_UNDEF_HI, 16'h0001, 8'hFF, 16'hFFFF, 1'b0);
    // fill the table, then one create too many
    for (i = 2; i < ttab_pkg::TABLE_DEPTH; i++)
      queue_command(ttab_pkg::CMD_CREATE, 16'(16'hA5A0 + i), 8'($urandom_range(0, 255)),
                    16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_CREATE, 16'h5A5A, 8'h42, 16'h0000, 1'b0);
    // delete at the last slot of a full table, then in the middle, then at the front
    queue_command(ttab_pkg::CMD_DELETE, 16'(16'hA5A0 + ttab_pkg::TABLE_DEPTH - 1), 8'h00,
                  16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_DELETE, 16'h0001, 8'h00, 16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_DELETE, 16'hFFFF, 8'h00, 16'h0000, 1'b0);
    queue_command(ttab_pkg::CMD_SLEEP, 16'h4321, 8'h00, 16'h0100, 1'b0);
    queue_command(ttab_pkg::CMD_WAKE, 16'h4321, 8'h00, 16'h0000, 1'b0);

    // id pool starts with the ids of the fill creates, then random nonzero ids
    for (i = 0; i < POOL_SIZE; i++)
      id_pool[i] = (i + 2 < ttab_pkg::TABLE_DEPTH) ? 16'(16'hA5A0 + i + 2)
                                                   : 16'($urandom_range(1, 65535));

    // random: mostly commands on a small id pool so hits, duplicates and full table recur
    for (i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        // retire a pool id, deleting it first so it does not stay stuck in the table
        p = $urandom_range(0, POOL_SIZE - 1);
        queue_command(ttab_pkg::CMD_DELETE, id_pool[p], 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 1'b0);
        id_pool[p] = 16'($urandom_range(1, 65535));
      end
      r = $urandom_range(0, 99);
      if (r < 28)      cmd = ttab_pkg::CMD_CREATE;
      else if (r < 46) cmd = ttab_pkg::CMD_DELETE;
      else if (r < 56) cmd = ttab_pkg::CMD_SUSPEND;
      else if (r < 66) cmd = ttab_pkg::CMD_RESUME;
      else if (r < 80) cmd = ttab_pkg::CMD_SLEEP;
      else if (r < 90) cmd = ttab_pkg::CMD_WAKE;
      else if (r < 94) cmd = r[0] ? CMD_UNDEF_HI : CMD_UNDEF_LO;
      else             cmd = 3'($urandom_range(0, 5));
      s = $urandom_range(0, 99);
      if (s < 3)
        id = '0;
      else if (s < 6 && cmd != ttab_pkg::CMD_CREATE)
        id = 16'($urandom_range(1, 65535));
      else
        id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      s = $urandom_range(0, 9);
      ticks = (s == 0) ? 16'h0000 : (s == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      queue_command(cmd, id, 8'($urandom_range(0, 255)), ticks,
                    (i == 0) || ($urandom_range(0, 149) == 0));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || n_seen != n_pred) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (reply_q.size() != 0) begin
      n_errors += reply_q.size();
      $display("%0t: %0d expected results never arrived", $time, reply_q.size());
    end
    $display("commands: create %0d, delete %0d, suspend %0d, resume %0d, sleep %0d, wake %0d,"
             , n_by_cmd[ttab_pkg::CMD_CREATE], n_by_cmd[ttab_pkg::CMD_DELETE],
             n_by_cmd[ttab_pkg::CMD_SUSPEND], n_by_cmd[ttab_pkg::CMD_RESUME],
             n_by_cmd[ttab_pkg::CMD_SLEEP], n_by_cmd[ttab_pkg::CMD_WAKE]);
    $display("undefined %0d; %0d results checked, %0d successful, %0d errors",
             n_by_cmd[CMD_UNDEF_LO] + n_by_cmd[CMD_UNDEF_HI], n_seen, n_ok, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
